// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the pending request table rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/prt_pkg.sv =====
// types, status codes and defaults for the pending request table
// no dependencies
`default_nettype none

package prt_pkg;

	localparam int PRT_ENTRIES      = 16;
	localparam int PRT_PAYLOAD_BITS = 32;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_EXISTS    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TAKE = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [63:0] req_key;
		logic        method_present;
		logic [31:0] entry_payload;
	} prt_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] payload_out;
		logic [31:0] sequence_out;
		logic [4:0]  occupancy;
	} prt_rsp_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_en;
	} prt_store_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_HIT,
		S_FETCH,
		S_RESP
	} prt_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/prt_store.sv =====
// slot storage: key, payload and stamp memories with registered read, valid flops
// depends on prt_pkg
`default_nettype none

module prt_store import prt_pkg::*; #(
	parameter int ENTRIES      = PRT_ENTRIES,
	parameter int PAYLOAD_BITS = PRT_PAYLOAD_BITS,
	localparam int IW          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire prt_store_ctl_t          ctl,
	input  wire logic [IW-1:0]           rd_addr,
	input  wire logic [IW-1:0]           wr_addr,
	input  wire logic [IW-1:0]           clr_addr,
	input  wire logic [63:0]             wr_key,
	input  wire logic [PAYLOAD_BITS-1:0] wr_payload,
	input  wire logic [31:0]             wr_stamp,
	output logic [63:0]                  rd_key,
	output logic [PAYLOAD_BITS-1:0]      rd_payload,
	output logic [31:0]                  rd_stamp,
	output logic [ENTRIES-1:0]           slot_valid
);

	logic [63:0]             key_mem   [ENTRIES];
	logic [PAYLOAD_BITS-1:0] pay_mem   [ENTRIES];
	logic [31:0]             stamp_mem [ENTRIES];
	logic [63:0]             rd_key_q;
	logic [PAYLOAD_BITS-1:0] rd_payload_q;
	logic [31:0]             rd_stamp_q;
	logic [ENTRIES-1:0]      valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			key_mem[wr_addr]   <= wr_key;
			pay_mem[wr_addr]   <= wr_payload;
			stamp_mem[wr_addr] <= wr_stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_key_q     <= key_mem[rd_addr];
			rd_payload_q <= pay_mem[rd_addr];
			rd_stamp_q   <= stamp_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.clr_en) begin
				valid_q[clr_addr] <= 1'b0;
			end
		end
	end

	assign rd_key     = rd_key_q;
	assign rd_payload = rd_payload_q;
	assign rd_stamp   = rd_stamp_q;
	assign slot_valid = valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/prt_seq.sv =====
// sequencer with the shared key comparator: scans slots one per cycle for add and take
// depends on prt_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module prt_seq import prt_pkg::*; #(
	parameter int ENTRIES      = PRT_ENTRIES,
	parameter int PAYLOAD_BITS = PRT_PAYLOAD_BITS,
	localparam int IW          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CW          = $clog2(ENTRIES + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	output logic                         req_ready,
	input  wire prt_req_t                req,
	output logic                         res_valid,
	input  wire logic                    res_ready,
	output prt_rsp_t                     res,
	output prt_store_ctl_t               ctl,
	output logic [IW-1:0]                rd_addr,
	output logic [IW-1:0]                wr_addr,
	output logic [IW-1:0]                clr_addr,
	output logic [63:0]                  wr_key,
	output logic [PAYLOAD_BITS-1:0]      wr_payload,
	output logic [31:0]                  wr_stamp,
	input  wire logic [63:0]             rd_key,
	input  wire logic [PAYLOAD_BITS-1:0] rd_payload,
	input  wire logic [31:0]             rd_stamp,
	input  wire logic [ENTRIES-1:0]      slot_valid
);

	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	prt_state_t      state_q, state_d;
	logic [IW-1:0]   idx_q;
	logic            cmp_v_q;
	logic [IW-1:0]   cmp_idx_q;
	logic            free_v_q;
	logic [IW-1:0]   free_idx_q;
	logic [IW-1:0]   found_idx_q;
	logic [31:0]     stamp_q;
	logic [CW-1:0]   live_q;
	logic            cmd_q;
	logic [63:0]     id_q;
	logic [31:0]     pay_q;
	prt_rsp_t        res_q;
	logic            hit;
	logic            accept;
	logic            bad_arg;
	logic            add_ok;

	function automatic logic [4:0] occ_f(input logic [CW-1:0] c);
		return 5'(32'(c));
	endfunction

	assign accept  = req_valid && req_ready;
	assign bad_arg = (req.req_key == 64'd0) ||
		(req.cmd == CMD_ADD && !req.method_present);
	assign hit     = cmp_v_q && slot_valid[cmp_idx_q] && (rd_key == id_q);
	assign add_ok  = (cmd_q == CMD_ADD) && free_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		res_valid  = 1'b0;
		ctl        = '0;
		rd_addr    = idx_q;
		wr_addr    = free_idx_q;
		clr_addr   = found_idx_q;
		wr_key     = id_q;
		wr_payload = PAYLOAD_BITS'(64'(pay_q));
		wr_stamp   = 32'(stamp_q + 32'd1);
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = bad_arg ? S_RESP : S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.rd_en = 1'b1;
				if (hit) begin
					state_d = S_HIT;
				end else if (idx_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (hit) begin
					state_d = S_HIT;
				end else begin
					ctl.wr_en = add_ok;
					state_d   = S_RESP;
				end
			end
			S_HIT: begin
				if (cmd_q == CMD_TAKE) begin
					ctl.rd_en  = 1'b1;
					ctl.clr_en = 1'b1;
					rd_addr    = found_idx_q;
					state_d    = S_FETCH;
				end else begin
					state_d = S_RESP;
				end
			end
			S_FETCH: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			cmp_v_q  <= 1'b0;
			free_v_q <= 1'b0;
			stamp_q  <= '0;
			live_q   <= '0;
		end else begin
			cmp_v_q <= (state_q == S_SCAN);
			if (state_q == S_IDLE && accept) begin
				idx_q    <= '0;
				free_v_q <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				idx_q <= IW'(idx_q + 1'b1);
				if (!slot_valid[idx_q] && !free_v_q) begin
					free_v_q <= 1'b1;
				end
			end
			if (state_q == S_DRAIN && !hit && add_ok) begin
				stamp_q <= 32'(stamp_q + 32'd1);
				live_q  <= CW'(live_q + 1'b1);
			end
			if (state_q == S_HIT && cmd_q == CMD_TAKE) begin
				live_q <= CW'(live_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= idx_q;
		if (state_q == S_IDLE && accept) begin
			cmd_q <= req.cmd;
			id_q  <= req.req_key;
			pay_q <= req.entry_payload;
			res_q <= '{ST_INVALID, 32'd0, 32'd0, occ_f(live_q)};
		end
		if (state_q == S_SCAN && !slot_valid[idx_q] && !free_v_q) begin
			free_idx_q <= idx_q;
		end
		if ((state_q == S_SCAN || state_q == S_DRAIN) && hit) begin
			found_idx_q <= cmp_idx_q;
		end
		if (state_q == S_DRAIN && !hit) begin
			if (cmd_q == CMD_TAKE) begin
				res_q <= '{ST_NOT_FOUND, 32'd0, 32'd0, occ_f(live_q)};
			end else if (free_v_q) begin
				res_q <= '{ST_OK, 32'd0, 32'(stamp_q + 32'd1),
					occ_f(CW'(live_q + 1'b1))};
			end else begin
				res_q <= '{ST_FULL, 32'd0, 32'd0, occ_f(live_q)};
			end
		end
		if (state_q == S_HIT && cmd_q == CMD_ADD) begin
			res_q <= '{ST_EXISTS, 32'd0, 32'd0, occ_f(live_q)};
		end
		if (state_q == S_FETCH) begin
			res_q <= '{ST_OK, 32'(64'(rd_payload)), rd_stamp, occ_f(live_q)};
		end
	end

	assign res = res_q;

	`ASSERT_ALWAYS(a_live_bound, clk, arst_n, 32'(live_q) <= ENTRIES)
	`ASSERT_ALWAYS(a_no_wr_clr, clk, arst_n, !(ctl.wr_en && ctl.clr_en))
	`ASSERT_SAME(a_wr_free_slot, clk, arst_n, ctl.wr_en, !slot_valid[wr_addr])
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE)

endmodule

`default_nettype wire

// ===== rtl/core/pending_request_table.sv =====
// Pending request table: up to ENTRIES records keyed by a nonzero 64-bit id.
// A request with a bad argument goes straight to the response state with no
// scan; every other request scans the key memory through one comparator, one
// slot per cycle, up to the last slot unless a hit ends the scan.
// A new request is taken only while the sequencer is idle; a finished
// response waits in the output register without holding up the next request.
// depends on prt_pkg, prt_seq, prt_store, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pending_request_table import prt_pkg::*; #(
	parameter int ENTRIES      = PRT_ENTRIES,
	parameter int PAYLOAD_BITS = PRT_PAYLOAD_BITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire prt_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output prt_rsp_t      rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	prt_store_ctl_t          ctl;
	logic [IW-1:0]           rd_addr;
	logic [IW-1:0]           wr_addr;
	logic [IW-1:0]           clr_addr;
	logic [63:0]             wr_key;
	logic [PAYLOAD_BITS-1:0] wr_payload;
	logic [31:0]             wr_stamp;
	logic [63:0]             rd_key;
	logic [PAYLOAD_BITS-1:0] rd_payload;
	logic [31:0]             rd_stamp;
	logic [ENTRIES-1:0]      slot_valid;
	logic                    res_valid;
	logic                    res_ready;
	prt_rsp_t                res;
	logic                    rsp_valid_q;
	prt_rsp_t                rsp_q;

	prt_seq #(
		.ENTRIES      (ENTRIES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.clr_addr   (clr_addr),
		.wr_key     (wr_key),
		.wr_payload (wr_payload),
		.wr_stamp   (wr_stamp),
		.rd_key     (rd_key),
		.rd_payload (rd_payload),
		.rd_stamp   (rd_stamp),
		.slot_valid (slot_valid)
	);

	prt_store #(
		.ENTRIES      (ENTRIES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.clr_addr   (clr_addr),
		.wr_key     (wr_key),
		.wr_payload (wr_payload),
		.wr_stamp   (wr_stamp),
		.rd_key     (rd_key),
		.rd_payload (rd_payload),
		.rd_stamp   (rd_stamp),
		.slot_valid (slot_valid)
	);

	// output register
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_NEXT(a_rsp_load, clk, arst_n, res_valid && res_ready, rsp_valid)
	`ASSERT_SAME(a_status_code, clk, arst_n, rsp_valid, rsp.status <= ST_NOT_FOUND)
	`ASSERT_SAME(a_fail_zero, clk, arst_n, rsp_valid && rsp.status != ST_OK,
		rsp.payload_out == 32'd0 && rsp.sequence_out == 32'd0)

endmodule

`default_nettype wire

// ===== tb/tb_pending_request_table.sv =====
// self-checking bench for pending_request_table: directed table then random add/take traffic
// responses are compared per field to typed directed rows or to this module's table model
// depends on prt_pkg and the pending_request_table rtl
`default_nettype none

module tb_pending_request_table;
	timeunit 1ns;
	timeprecision 1ps;

	import prt_pkg::*;

	localparam int ENTRIES     = PRT_ENTRIES;
	localparam int RAND_ITEMS  = 2000;
	localparam int QUIET_TAIL  = 300;
	localparam int DRAIN_AT    = 1000;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 30;
	localparam int IDLE_LIMIT  = 3000;

	typedef struct packed {
		logic        cmd;
		logic [63:0] id;
		logic        method;
		logic [31:0] payload;
		logic [4:0]  reps;
		logic        typed;
		prt_rsp_t    rsp;
	} dir_row_t;

	localparam logic [63:0] ID_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ID_TOP  = 64'h8000_0000_0000_0000;
	localparam int DIR_N = 15;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{CMD_TAKE, 64'd1,   1'b0, 32'h0,          5'd1,  1'b1, '{ST_NOT_FOUND, 32'h0, 32'd0, 5'd0}},
		'{CMD_ADD,  64'd0,   1'b1, 32'h1234,       5'd1,  1'b1, '{ST_INVALID, 32'h0, 32'd0, 5'd0}},
		'{CMD_ADD,  64'd5,   1'b0, 32'h5555,       5'd1,  1'b1, '{ST_INVALID, 32'h0, 32'd0, 5'd0}},
		'{CMD_TAKE, 64'd0,   1'b1, 32'h0,          5'd1,  1'b1, '{ST_INVALID, 32'h0, 32'd0, 5'd0}},
		'{CMD_ADD,  ID_ONES, 1'b1, 32'hFFFF_FFFF,  5'd1,  1'b1, '{ST_OK, 32'h0, 32'd1, 5'd1}},
		'{CMD_ADD,  ID_ONES, 1'b1, 32'h0,          5'd1,  1'b1, '{ST_EXISTS, 32'h0, 32'd0, 5'd1}},
		'{CMD_ADD,  ID_ONES, 1'b0, 32'h0,          5'd1,  1'b1, '{ST_INVALID, 32'h0, 32'd0, 5'd1}},
		'{CMD_TAKE, ID_ONES, 1'b0, 32'h0,          5'd1,  1'b1,
			'{ST_OK, 32'hFFFF_FFFF, 32'd1, 5'd0}},
		'{CMD_TAKE, ID_ONES, 1'b1, 32'h0,          5'd1,  1'b1, '{ST_NOT_FOUND, 32'h0, 32'd0, 5'd0}},
		'{CMD_ADD,  64'd1,   1'b1, 32'hA5A5_0000,  5'd16, 1'b0, '0},
		'{CMD_ADD,  ID_TOP,  1'b1, 32'h1,          5'd1,  1'b1, '{ST_FULL, 32'h0, 32'd0, 5'd16}},
		'{CMD_TAKE, 64'd7,   1'b1, 32'h0,          5'd1,  1'b0, '0},
		'{CMD_ADD,  ID_TOP,  1'b1, 32'h0,          5'd1,  1'b0, '0},
		'{CMD_TAKE, 64'd1,   1'b0, 32'h0,          5'd16, 1'b0, '0},
		'{CMD_TAKE, ID_TOP,  1'b1, 32'h0,          5'd1,  1'b0, '0}
	};

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	prt_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	prt_rsp_t rsp;

	bit          slot_live [ENTRIES];
	logic [63:0] slot_id [ENTRIES];
	logic [31:0] slot_word [ENTRIES];
	logic [31:0] slot_seq [ENTRIES];
	logic [31:0] seq_ctr;
	int          live_cnt;

	prt_rsp_t owed_rsps [$];
	int       errors;
	bit       filling;
	bit       quiet;
	int       idle_cycles;

	pending_request_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic prt_rsp_t table_apply(prt_req_t r);
		prt_rsp_t o;
		int hit;
		int free;
		o = '0;
		hit = -1;
		free = -1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (slot_live[i] && slot_id[i] == r.req_key)
				hit = i;
			if (!slot_live[i])
				free = i;
		end
		if (r.cmd == CMD_ADD) begin
			if (r.req_key == 64'd0 || !r.method_present) begin
				o.status = ST_INVALID;
			end else if (hit >= 0) begin
				o.status = ST_EXISTS;
			end else if (free < 0) begin
				o.status = ST_FULL;
			end else begin
				seq_ctr = seq_ctr + 32'd1;
				slot_live[free] = 1'b1;
				slot_id[free] = r.req_key;
				slot_word[free] = r.entry_payload;
				slot_seq[free] = seq_ctr;
				live_cnt++;
				o.status = ST_OK;
				o.sequence_out = seq_ctr;
			end
		end else begin
			if (r.req_key == 64'd0) begin
				o.status = ST_INVALID;
			end else if (hit < 0) begin
				o.status = ST_NOT_FOUND;
			end else begin
				o.status = ST_OK;
				o.payload_out = slot_word[hit];
				o.sequence_out = slot_seq[hit];
				slot_live[hit] = 1'b0;
				if (live_cnt > 0)
					live_cnt--;
			end
		end
		o.occupancy = live_cnt[4:0];
		return o;
	endfunction

	function automatic logic [63:0] fresh_id();
		logic [63:0] id;
		case ($urandom_range(0, 9))
			0: id = 64'($urandom_range(1, 40));
			1: id = ID_ONES;
			default: id = {$urandom, $urandom};
		endcase
		if (id == 64'd0)
			id = 64'd1;
		return id;
	endfunction

	function automatic logic [63:0] any_live_id();
		int pick;
		logic [63:0] id;
		pick = $urandom_range(0, live_cnt - 1);
		id = 64'd0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_live[i]) begin
				if (pick == 0)
					id = slot_id[i];
				pick--;
			end
		end
		return id;
	endfunction

	function automatic prt_req_t random_req();
		prt_req_t r;
		int roll;
		int add_new;
		add_new = filling ? 55 : 20;
		roll = $urandom_range(0, 99);
		r.cmd = CMD_ADD;
		r.req_key = fresh_id();
		r.method_present = 1'b1;
		case ($urandom_range(0, 7))
			0: r.entry_payload = 32'h0;
			1: r.entry_payload = 32'hFFFF_FFFF;
			default: r.entry_payload = $urandom;
		endcase
		if (roll < add_new) begin
		end else if (roll < 75) begin
			r.cmd = CMD_TAKE;
			r.method_present = 1'($urandom);
			if (live_cnt != 0)
				r.req_key = any_live_id();
		end else if (roll < 85) begin
			if (live_cnt != 0)
				r.req_key = any_live_id();
		end else if (roll < 92) begin
			r.cmd = CMD_TAKE;
			r.method_present = 1'($urandom);
		end else if (roll < 96) begin
			if ($urandom_range(0, 1) == 0) begin
				r.req_key = 64'd0;
				r.method_present = 1'($urandom);
			end else begin
				r.method_present = 1'b0;
			end
		end else begin
			r.cmd = CMD_TAKE;
			r.req_key = 64'd0;
			r.method_present = 1'($urandom);
		end
		return r;
	endfunction

	task automatic send_req(input prt_req_t item, input bit typed, input prt_rsp_t typed_rsp);
		prt_rsp_t predicted;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		predicted = table_apply(item);
		owed_rsps.push_back(typed ? typed_rsp : predicted);
	endtask

	task automatic flag_field(input string name, input logic [63:0] exp, input logic [63:0] act);
		if (act !== exp) begin
			errors++;
			$display("%0t %s: expected %h, actual %h", $time, name, exp, act);
		end
	endtask

	initial begin
		prt_req_t item;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		filling = 1'b1;
		quiet = 1'b0;
		seq_ctr = 32'd0;
		live_cnt = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_live[i] = 1'b0;
			slot_id[i] = 64'd0;
			slot_word[i] = 32'd0;
			slot_seq[i] = 32'd0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_N; r++) begin
			for (int k = 0; k < int'(DIR_ROWS[r].reps); k++) begin
				item.cmd = DIR_ROWS[r].cmd;
				item.req_key = DIR_ROWS[r].id + 64'(k);
				item.method_present = DIR_ROWS[r].method;
				item.entry_payload = DIR_ROWS[r].payload + 32'(k);
				send_req(item, DIR_ROWS[r].typed, DIR_ROWS[r].rsp);
			end
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			filling = ((n / 120) % 2) == 0;
			if (n == RAND_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			if (n == DRAIN_AT) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (owed_rsps.size() != 0) @(posedge clk);
			end
			send_req(random_req(), 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (owed_rsps.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		prt_rsp_t exp;
		int stall;
		int got;
		bit held;
		errors = 0;
		rsp_ready = 1'b0;
		stall = 0;
		got = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				got++;
				if (owed_rsps.size() == 0) begin
					errors++;
					$display("%0t response with none expected: actual %h", $time, rsp);
				end else begin
					exp = owed_rsps.pop_front();
					flag_field("status", 64'(exp.status), 64'(rsp.status));
					flag_field("payload_out", 64'(exp.payload_out), 64'(rsp.payload_out));
					flag_field("sequence_out", 64'(exp.sequence_out), 64'(rsp.sequence_out));
					flag_field("occupancy", 64'(exp.occupancy), 64'(rsp.occupancy));
				end
			end
			if (!held && got >= HOLD_AT) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end
			if (quiet) begin
				stall = 0;
				rsp_ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				rsp_ready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 4) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t no request or response moved for %0d cycles", $time, IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
